/* sv/rgga_pkg.sv */
// ----------------------------------------------------------------------------
// rgga_pkg
// Shared constants and types for the range gated group averager.
// ----------------------------------------------------------------------------
package rgga_pkg;

	// field widths
	localparam int DATA_W        = 16;
	localparam int KEPT_W        = 8;
	localparam int MAX_GROUP_DEF = 128;

	// configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 1'b1;

	// reset values of the bounds, Q4.12
	localparam logic [DATA_W-1:0] LOW_BOUND_RST  = 16'd205;
	localparam logic [DATA_W-1:0] HIGH_BOUND_RST = 16'd40919;

	// divider status seen by the top level
	typedef struct packed {
		logic idle;  // ready to take a new group
		logic done;  // result held, waiting for the output register
	} div_stat_t;

endpackage

/* sv/rgga_accum.sv */
// ----------------------------------------------------------------------------
// rgga_accum
// Range gate plus running sum and count of kept samples for one group.
// ----------------------------------------------------------------------------
module rgga_accum import rgga_pkg::*; #(
	parameter int MAX_GROUP = MAX_GROUP_DEF,
	parameter int CNT_W     = $clog2(MAX_GROUP + 1),
	parameter int SUM_W     = DATA_W + $clog2(MAX_GROUP)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [DATA_W-1:0] sample,
	input  logic              end_of_group,
	input  logic [DATA_W-1:0] low_bound,
	input  logic [DATA_W-1:0] high_bound,
	output logic              launch,
	output logic [SUM_W-1:0]  grp_sum,
	output logic [CNT_W-1:0]  grp_cnt
);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             keep;

	// gate: inside bounds and group not full
	assign keep = (sample >= low_bound) && (sample <= high_bound) &&
	              (cnt_q < CNT_W'(MAX_GROUP));

	// totals including the current item
	assign grp_sum = keep ? sum_q + SUM_W'(sample) : sum_q;
	assign grp_cnt = keep ? cnt_q + CNT_W'(1) : cnt_q;
	assign launch  = accept && end_of_group;

	// running totals, cleared at group end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (end_of_group) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= grp_sum;
				cnt_q <= grp_cnt;
			end
		end
	end

endmodule

/* sv/rgga_div.sv */
// ----------------------------------------------------------------------------
// rgga_div
// Bit-serial restoring divider: one quotient bit per cycle, sum by count.
// ----------------------------------------------------------------------------
module rgga_div import rgga_pkg::*; #(
	parameter int MAX_GROUP = MAX_GROUP_DEF,
	parameter int CNT_W     = $clog2(MAX_GROUP + 1),
	parameter int SUM_W     = DATA_W + $clog2(MAX_GROUP)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	input  logic              ack,
	output div_stat_t         stat,
	output logic [DATA_W-1:0] quot,
	output logic [CNT_W-1:0]  count,
	output logic              empty
);

	localparam int ITER_W = $clog2(SUM_W);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	state_t            state_q;
	logic [ITER_W-1:0] iter_q;
	logic [SUM_W-1:0]  quo_q;   // dividend shifts out, quotient shifts in
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              empty_q;
	logic [CNT_W:0]    trial;
	logic              fits;
	logic [CNT_W:0]    diff;

	// one restoring step
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q  <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			div_q   <= '0;
			empty_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						quo_q   <= dividend;
						rem_q   <= '0;
						div_q   <= divisor;
						iter_q  <= ITER_W'(SUM_W - 1);
						empty_q <= (divisor == '0);
						state_q <= (divisor == '0) ? S_DONE : S_RUN;
					end
				end
				S_RUN: begin
					rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], fits};
					if (iter_q == '0) begin
						state_q <= S_DONE;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	// empty group reads as zero mean
	assign quot  = empty_q ? '0 : quo_q[DATA_W-1:0];
	assign count = div_q;
	assign empty = empty_q;

endmodule

/* sv/range_gated_group_averager.sv */
// ----------------------------------------------------------------------------
// range_gated_group_averager
// Gates Q4.12 samples against a bound window, sums kept samples per group and
// gives the truncated mean, count and empty flag at each group end.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  sample, end_of_group
// out       output     out_valid/out_ready mean, kept_count, empty_group
// cfg       input      cfg_we             cfg_index, cfg_data
//
// Samples without group end are taken back to back while the divider is idle.
// A group end runs the serial divider, one quotient bit per cycle; an empty
// group skips it. in_ready stays low until the result has moved into the
// output register.
// Output stalls hold the result; the next group accumulates meanwhile.
// Reset restores the default bounds and clears sum, count and valid flags.
// ----------------------------------------------------------------------------
module range_gated_group_averager import rgga_pkg::*; #(
	parameter int MAX_GROUP = MAX_GROUP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DATA_W-1:0]    sample,
	input  logic                 end_of_group,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    mean,
	output logic [KEPT_W-1:0]    kept_count,
	output logic                 empty_group,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int SUM_W = DATA_W + $clog2(MAX_GROUP);

	logic [DATA_W-1:0] low_bound_q;
	logic [DATA_W-1:0] high_bound_q;
	logic              accept;
	logic              launch;
	logic [SUM_W-1:0]  grp_sum;
	logic [CNT_W-1:0]  grp_cnt;
	div_stat_t         div_stat;
	logic              div_ack;
	logic [DATA_W-1:0] div_quot;
	logic [CNT_W-1:0]  div_count;
	logic              div_empty;
	logic              out_valid_q;
	logic [DATA_W-1:0] mean_q;
	logic [KEPT_W-1:0] kept_q;
	logic              empty_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q  <= LOW_BOUND_RST;
			high_bound_q <= HIGH_BOUND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_BOUND:  low_bound_q  <= cfg_data;
				CFG_HIGH_BOUND: high_bound_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = div_stat.idle;
	assign accept   = in_valid && in_ready;

	rgga_accum #(
		.MAX_GROUP (MAX_GROUP),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample       (sample),
		.end_of_group (end_of_group),
		.low_bound    (low_bound_q),
		.high_bound   (high_bound_q),
		.launch       (launch),
		.grp_sum      (grp_sum),
		.grp_cnt      (grp_cnt)
	);

	rgga_div #(
		.MAX_GROUP (MAX_GROUP),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch),
		.dividend (grp_sum),
		.divisor  (grp_cnt),
		.ack      (div_ack),
		.stat     (div_stat),
		.quot     (div_quot),
		.count    (div_count),
		.empty    (div_empty)
	);

	// result moves out when the output register is free
	assign div_ack = div_stat.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ack) begin
			mean_q  <= div_quot;
			kept_q  <= KEPT_W'(div_count);
			empty_q <= div_empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign mean        = mean_q;
	assign kept_count  = kept_q;
	assign empty_group = empty_q;

endmodule

/* sv/rgga_checker.sv */
// ----------------------------------------------------------------------------
// rgga_checker
// Port level checks for the range gated group averager, bound to the top.
// ----------------------------------------------------------------------------
module rgga_checker import rgga_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 end_of_group,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DATA_W-1:0]    mean,
	input logic [KEPT_W-1:0]    kept_count,
	input logic                 empty_group
);

	// stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out item dropped while stalled");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(mean) && $stable(kept_count) && $stable(empty_group))
		else $error("out payload changed while stalled");

	// empty group gives zero mean and count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_group |-> (mean == '0) && (kept_count == '0))
		else $error("empty group with nonzero mean or count");

	// a group end blocks input while the divider works
	a_eog_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_group |=> !in_ready)
		else $error("input taken right after group end");

	// a new result only follows a cycle with input blocked
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a group end");

endmodule

bind range_gated_group_averager rgga_checker u_rgga_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.end_of_group (end_of_group),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.mean         (mean),
	.kept_count   (kept_count),
	.empty_group  (empty_group)
);

/* tb/range_gated_group_averager_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_gated_group_averager_tb
// Drives Q4.12 samples through the bound window and checks every group result
// (mean, kept count, empty flag) against an in-bench predictor. Covers window
// edges, empty groups, inverted and single-point windows, group overflow,
// a long output stall, and random groups under changing bounds and idling.
// ----------------------------------------------------------------------------
module range_gated_group_averager_tb;
	import rgga_pkg::*;

	localparam int GROUP_CAP = MAX_GROUP_DEF;

	typedef struct {
		logic [DATA_W-1:0] mean;
		logic [KEPT_W-1:0] kept;
		logic              empty;
	} group_result_t;

	// DUT inputs, known from time zero
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic [DATA_W-1:0]    sample       = '0;
	logic                 end_of_group = 1'b0;
	logic                 out_ready    = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_LOW_BOUND;
	logic [DATA_W-1:0]    cfg_data     = '0;

	logic              in_ready;
	logic              out_valid;
	logic [DATA_W-1:0] mean;
	logic [KEPT_W-1:0] kept_count;
	logic              empty_group;

	// predictor state and bound mirror
	logic [DATA_W-1:0] bound_lo    = LOW_BOUND_RST;
	logic [DATA_W-1:0] bound_hi    = HIGH_BOUND_RST;
	int unsigned       group_sum   = 0;
	int unsigned       kept_so_far = 0;

	group_result_t pending_results[$];

	int          errors        = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned stall_left    = 0;

	range_gated_group_averager #(
		.MAX_GROUP(GROUP_CAP)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.end_of_group (end_of_group),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean         (mean),
		.kept_count   (kept_count),
		.empty_group  (empty_group),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// gate one sample, accumulate, and produce the group result on its end
	function automatic void gate_and_average(input logic [DATA_W-1:0] s, input logic eog,
			output bit has_res, output group_result_t res);
		has_res = eog;
		res = '{mean: '0, kept: '0, empty: 1'b0};
		if (s >= bound_lo && s <= bound_hi && kept_so_far < GROUP_CAP) begin
			group_sum += s;
			kept_so_far++;
		end
		if (eog) begin
			if (kept_so_far == 0) begin
				res.empty = 1'b1;
			end else begin
				res.mean = DATA_W'(group_sum / kept_so_far);
				res.kept = KEPT_W'(kept_so_far);
			end
			group_sum   = 0;
			kept_so_far = 0;
		end
	endfunction

	// random sample: mostly inside or at the window edges, some anywhere; outside the window on request
	function automatic logic [DATA_W-1:0] pick_sample(input bit out_of_window);
		int r;
		r = $urandom_range(99);
		if (out_of_window) begin
			if (bound_lo > bound_hi || (bound_lo == 0 && bound_hi == 16'hFFFF))
				return DATA_W'($urandom_range(16'hFFFF, 0));
			if (bound_lo > 0 && (bound_hi == 16'hFFFF || r < 50))
				return DATA_W'($urandom_range(bound_lo - 1, 0));
			return DATA_W'($urandom_range(16'hFFFF, bound_hi + 1));
		end
		if (r < 45 && bound_lo <= bound_hi)
			return DATA_W'($urandom_range(bound_hi, bound_lo));
		if (r < 60) begin
			case (r % 4)
				0: return bound_lo;
				1: return bound_hi;
				2: return bound_lo - 1'b1;
				default: return bound_hi + 1'b1;
			endcase
		end
		return DATA_W'($urandom_range(16'hFFFF, 0));
	endfunction

	// mostly short groups, a few past the group cap
	function automatic int random_group_len();
		int r;
		r = $urandom_range(99);
		if (r < 90)
			return $urandom_range(16, 1);
		if (r < 98)
			return $urandom_range(60, 17);
		return $urandom_range(GROUP_CAP + 7, GROUP_CAP - 8);
	endfunction

	// offer one item, wait for its acceptance, record the expected result
	task automatic send_sample(input logic [DATA_W-1:0] s, input logic eog);
		bit            has_res;
		group_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample       <= s;
		end_of_group <= eog;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		gate_and_average(s, eog, has_res, res);
		if (has_res)
			pending_results.push_back(res);
	endtask

	task automatic send_group(input int len, input bit out_of_window);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(out_of_window), i == len - 1);
	endtask

	// stop offering, wait for all results, then let the divider settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// write both bounds while the block is idle
	task automatic set_bounds(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOW_BOUND;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_HIGH_BOUND;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we   <= 1'b0;
		bound_lo = lo;
		bound_hi = hi;
	endtask

	task automatic pick_bounds(input int kind);
		int lo;
		int hi;
		int tmp;
		case (kind)
			0: begin lo = LOW_BOUND_RST; hi = HIGH_BOUND_RST; end
			1: begin lo = 0; hi = 16'hFFFF; end
			2: begin lo = $urandom_range(16'hFFFF, 0); hi = lo; end
			3: begin
				lo = $urandom_range(16'hFFFF, 1);
				hi = $urandom_range(lo - 1, 0);
			end
			4: begin
				lo = $urandom_range(16'hFFFF, 0);
				hi = $urandom_range(16'hFFFF, 0);
				if (lo > hi) begin
					tmp = lo;
					lo  = hi;
					hi  = tmp;
				end
			end
			5: begin
				lo = $urandom_range(16'hFFFF, 0);
				hi = lo + $urandom_range(64, 0);
				if (hi > 16'hFFFF)
					hi = 16'hFFFF;
			end
			default: begin lo = 16'hFFFF; hi = 0; end
		endcase
		set_bounds(DATA_W'(lo), DATA_W'(hi));
	endtask

	// window edges at the reset bounds, plus a single-sample and an empty group
	task automatic test_reset_bounds();
		send_idle_pct = 33;
		recv_idle_pct = 71;
		send_sample(16'd204, 1'b0);
		send_sample(LOW_BOUND_RST, 1'b0);
		send_sample(HIGH_BOUND_RST, 1'b0);
		send_sample(16'd40920, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(LOW_BOUND_RST, 1'b1);
		send_sample(16'd0, 1'b1);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b1);
	endtask

	// low above high keeps nothing; low equal to high keeps one value only
	task automatic test_inverted_and_point_window();
		set_bounds(16'd1000, 16'd999);
		send_sample(16'd999, 1'b0);
		send_sample(16'd1000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		set_bounds(16'hFFFF, 16'd0);
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		set_bounds(16'd777, 16'd777);
		send_sample(16'd776, 1'b0);
		send_sample(16'd777, 1'b0);
		send_sample(16'd778, 1'b1);
	endtask

	// full window; groups past the cap drop the extra samples
	task automatic test_full_window_overflow();
		set_bounds(16'd0, 16'hFFFF);
		for (int i = 0; i < GROUP_CAP + 2; i++)
			send_sample(16'hFFFF, i == GROUP_CAP + 1);
		for (int i = 0; i < GROUP_CAP + 1; i++)
			send_sample(16'd0, 1'b0);
		send_sample(16'd1, 1'b1);
		for (int i = 0; i < GROUP_CAP; i++)
			send_sample(DATA_W'($urandom_range(16'hFFFF, 0)), i == GROUP_CAP - 1);
	endtask

	// long output stall while short groups keep coming, so the input backs up
	task automatic test_backpressure();
		set_bounds(LOW_BOUND_RST, HIGH_BOUND_RST);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_left    = 400;
		for (int g = 0; g < 20; g++)
			send_group($urandom_range(3, 1), 1'b0);
	endtask

	// random groups over several bound settings and idling modes
	task automatic test_random_groups();
		int sent;
		int len;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 33; recv_idle_pct = 71; end
				1: begin send_idle_pct = 71; recv_idle_pct = 33; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int phase = 0; phase < 4; phase++) begin
				pick_bounds((mode * 4 + phase) % 7);
				sent = 0;
				while (sent < 70) begin
					len = random_group_len();
					send_group(len, $urandom_range(99) < 6);
					sent += len;
				end
			end
		end
	endtask

	// output ready, with random idling and counted hold-offs
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		group_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: mean %0d kept_count %0d empty_group %0d",
					mean, kept_count, empty_group);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (mean !== exp_res.mean) begin
					$error("mean: expected %0d, actual %0d", exp_res.mean, mean);
					errors++;
				end
				if (kept_count !== exp_res.kept) begin
					$error("kept_count: expected %0d, actual %0d", exp_res.kept, kept_count);
					errors++;
				end
				if (empty_group !== exp_res.empty) begin
					$error("empty_group: expected %0d, actual %0d", exp_res.empty, empty_group);
					errors++;
				end
			end
		end
	end

	// reset, then the tests in turn
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_bounds();
		test_inverted_and_point_window();
		test_full_window_overflow();
		test_backpressure();
		test_random_groups();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* range_gated_group_averager.f */
sv/rgga_pkg.sv
sv/rgga_accum.sv
sv/rgga_div.sv
sv/range_gated_group_averager.sv
sv/rgga_checker.sv
tb/range_gated_group_averager_tb.sv
